// ===== rtl/core/pmu_pkg.sv =====
`timescale 1ns / 1ps
// pmu_pkg: shared types, constants and the palette lookup for the spark motion update
// no dependencies; imported by every module in rtl/core

package pmu_pkg;

  // fixed point scale of the fade factor and the acceleration register
  localparam int unsigned FRAC_SHIFT = 8;
  localparam int unsigned FRAC_ONE   = 1 << FRAC_SHIFT;
  // fade factor spans 0 .. FRAC_ONE inclusive
  localparam int unsigned FADE_W     = FRAC_SHIFT + 1;

  // shade index resolution
  localparam int unsigned NUM_SHADES = 8;
  localparam int unsigned SHADE_W    = $clog2(NUM_SHADES);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL   = 1'b0,
    REG_GRAVITY = 1'b1
  } pmu_reg_e;

  localparam logic [15:0] ACCEL_RESET   = 16'd1024;
  localparam logic [7:0]  GRAVITY_RESET = 8'd8;

  // palette codes
  typedef enum logic [1:0] {
    PAL_RED    = 2'd0,
    PAL_GREEN  = 2'd1,
    PAL_PURPLE = 2'd2,
    PAL_NONE   = 2'd3
  } pmu_pal_e;

  localparam logic [7:0] RED_SHADES    [NUM_SHADES] = '{8'd224, 8'd192, 8'd160, 8'd128,
                                                        8'd96, 8'd64, 8'd32, 8'd0};
  localparam logic [7:0] GREEN_SHADES  [NUM_SHADES] = '{8'd24, 8'd20, 8'd16, 8'd8,
                                                        8'd12, 8'd8, 8'd4, 8'd0};
  localparam logic [7:0] PURPLE_SHADES [NUM_SHADES] = '{8'd249, 8'd213, 8'd177, 8'd141,
                                                        8'd105, 8'd69, 8'd33, 8'd0};

  // input transaction
  typedef struct packed {
    logic [15:0]        x_pos;
    logic [15:0]        y_pos;
    logic signed [15:0] x_grad;
    logic signed [15:0] y_grad;
    logic [15:0]        life_now;
    logic [15:0]        life_max;
    logic [1:0]         palette_select;
    logic               last_in;
  } pmu_in_t;

  // result transaction
  typedef struct packed {
    logic [15:0]        x_next;
    logic [15:0]        y_next;
    logic signed [15:0] x_grad_next;
    logic signed [15:0] y_grad_next;
    logic [15:0]        life_next;
    logic               alive;
    logic [2:0]         shade_index;
    logic [7:0]         colour;
    logic               last_out;
  } pmu_out_t;

  // per item context carried down the pipeline
  typedef struct packed {
    logic [15:0]        x_pos;
    logic [15:0]        y_pos;
    logic signed [15:0] x_grad;
    logic signed [15:0] y_grad;
    logic [15:0]        life_next;
    logic [15:0]        life_max;
    logic [1:0]         palette_select;
    logic               last_in;
    logic               alive_in;
    logic               alive_out;
  } pmu_ctx_t;

  // palette byte for a palette code and shade
  function automatic logic [7:0] pal_colour(input logic [1:0] pal,
                                            input logic [SHADE_W-1:0] shade);
    logic [7:0] c;
    c = 8'd0;
    case (pmu_pal_e'(pal))
      PAL_RED:    c = RED_SHADES[shade];
      PAL_GREEN:  c = GREEN_SHADES[shade];
      PAL_PURPLE: c = PURPLE_SHADES[shade];
      default:    c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/pmu_fade_div.sv =====
`timescale 1ns / 1ps
// pmu_fade_div: pipelined restoring divider, one quotient bit per stage, for the fade factor;
// the last stages also form the shade index. depends on pmu_pkg

module pmu_fade_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  pmu_pkg::pmu_ctx_t             ctx_i,
  input  logic [15:0]                   diff_i,
  output logic                          valid_o,
  output pmu_pkg::pmu_ctx_t             ctx_o,
  output logic [pmu_pkg::FADE_W-1:0]    fade_o,
  output logic [pmu_pkg::SHADE_W-1:0]   shade_o
);
  import pmu_pkg::*;

  localparam int unsigned DIV_STAGES = FADE_W;

  // index 0 is the stage input, index k+1 the register after step k
  logic [DIV_STAGES:0]  vld;
  pmu_ctx_t             ctx  [DIV_STAGES+1];
  logic [16:0]          rem  [DIV_STAGES+1];
  logic [FADE_W-1:0]    quot [DIV_STAGES+1];
  logic [16:0]          srem [DIV_STAGES+1];
  logic [SHADE_W-1:0]   squot [DIV_STAGES+1];

  // stage input: fade dividend is the remaining life, shade dividend the new life
  assign vld[0]   = valid_i;
  assign ctx[0]   = ctx_i;
  assign rem[0]   = {1'b0, diff_i};
  assign quot[0]  = '0;
  assign srem[0]  = {1'b0, ctx_i.life_next};
  assign squot[0] = '0;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    logic [16:0]        trial;
    logic               ge;
    logic [16:0]        rem_d;
    logic [FADE_W-1:0]  quot_d;
    logic [16:0]        strial;
    logic               sge;
    logic [16:0]        srem_d;
    logic [SHADE_W-1:0] squot_d;

    // fade step: the first bit compares without a shift (quotient may equal FRAC_ONE)
    always_comb begin
      if (k == 0) begin
        trial = rem[k];
      end else begin
        trial = {rem[k][15:0], 1'b0};
      end
      ge     = (trial >= {1'b0, ctx[k].life_max});
      rem_d  = ge ? (trial - {1'b0, ctx[k].life_max}) : trial;
      quot_d = {quot[k][FADE_W-2:0], ge};
    end

    // shade step, active in the last SHADE_W stages
    always_comb begin
      strial = {srem[k][15:0], 1'b0};
      sge    = (strial >= {1'b0, ctx[k].life_max});
      if (k >= DIV_STAGES - SHADE_W) begin
        srem_d  = sge ? (strial - {1'b0, ctx[k].life_max}) : strial;
        squot_d = {squot[k][SHADE_W-2:0], sge};
      end else begin
        srem_d  = srem[k];
        squot_d = squot[k];
      end
    end

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    // payload
    always_ff @(posedge clk_i) begin
      ctx[k+1]   <= ctx[k];
      rem[k+1]   <= rem_d;
      quot[k+1]  <= quot_d;
      srem[k+1]  <= srem_d;
      squot[k+1] <= squot_d;
    end
  end

  assign valid_o = vld[DIV_STAGES];
  assign ctx_o   = ctx[DIV_STAGES];
  assign fade_o  = quot[DIV_STAGES];
  assign shade_o = squot[DIV_STAGES];

endmodule

// ===== rtl/core/pmu_scale.sv =====
`timescale 1ns / 1ps
// pmu_scale: two stage signed multiply lane, gradient by fade then by acceleration,
// each quotient by FRAC_ONE truncating toward zero. depends on pmu_pkg

module pmu_scale (
  input  logic                        clk_i,
  input  logic signed [15:0]          grad_i,
  input  logic [pmu_pkg::FADE_W-1:0]  fade_i,
  input  logic [15:0]                 accel_i,
  output logic [15:0]                 move_o
);
  import pmu_pkg::*;

  localparam int unsigned PROD_W  = 16 + FADE_W + 1;
  localparam int unsigned PART_W  = PROD_W - FRAC_SHIFT;
  localparam int unsigned PROD2_W = PART_W + 17;

  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [PROD_W-1:0]  bias_sum;
  logic signed [PART_W-1:0]  part;
  logic signed [PROD2_W-1:0] prod2_d, prod2_q;
  logic signed [PROD2_W-1:0] bias_sum2;

  // first product: gradient times fade
  assign prod_d = grad_i * $signed({1'b0, fade_i});

  // divide by FRAC_ONE toward zero, then times acceleration
  always_comb begin
    bias_sum = prod_q + $signed({{(PROD_W-FRAC_SHIFT){1'b0}},
                                 {FRAC_SHIFT{prod_q[PROD_W-1]}}});
    part     = bias_sum[PROD_W-1:FRAC_SHIFT];
    prod2_d  = part * $signed({1'b0, accel_i});
  end

  // final divide toward zero, keep the low 16 bits
  always_comb begin
    bias_sum2 = prod2_q + $signed({{(PROD2_W-FRAC_SHIFT){1'b0}},
                                   {FRAC_SHIFT{prod2_q[PROD2_W-1]}}});
    move_o    = bias_sum2[FRAC_SHIFT+15:FRAC_SHIFT];
  end

  // product registers
  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    prod2_q <= prod2_d;
  end

endmodule

// ===== rtl/core/particle_motion_update_top.sv =====
`timescale 1ns / 1ps
// particle_motion_update_top: spark motion step with fade, acceleration, gravity and shade lookup
// depends on pmu_pkg, pmu_fade_div and pmu_scale

// One spark record is taken in every clock cycle (busy is always low) and its result appears
// on result_o for exactly one cycle, marked by result_valid_o; results come in
// input order and cannot be held off, so the receiver must take each one when it is shown.
// Each record passes one input register, nine divider stages (one fade quotient bit each, the last
// three also giving the shade index), two multiplier stages and the output register.
// acceleration and gravity are written through cfg_we_i / cfg_idx_i / cfg_wdata_i and should be
// changed only while no transaction is in flight.

module particle_motion_update_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  pmu_pkg::pmu_in_t                    item_i,
  output logic                                result_valid_o,
  output pmu_pkg::pmu_out_t                   result_o,
  input  logic                                cfg_we_i,
  input  logic [pmu_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pmu_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import pmu_pkg::*;

  logic [15:0]          accel_q;
  logic [7:0]           gravity_q;

  logic                 accept;
  pmu_ctx_t             in_ctx_d, in_ctx_q;
  logic [15:0]          in_diff_d, in_diff_q;
  logic                 in_vld_q;

  logic                 dv_vld;
  pmu_ctx_t             dv_ctx;
  logic [FADE_W-1:0]    dv_fade;
  logic [SHADE_W-1:0]   dv_shade;

  logic                 sc1_vld_q, sc2_vld_q;
  pmu_ctx_t             sc1_ctx_q, sc2_ctx_q;
  logic [SHADE_W-1:0]   sc1_shade_q, sc2_shade_q;
  logic [15:0]          move_x, move_y;

  pmu_out_t             result_d, result_q;
  logic                 result_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q   <= ACCEL_RESET;
      gravity_q <= GRAVITY_RESET;
    end else if (cfg_we_i) begin
      case (pmu_reg_e'(cfg_idx_i))
        REG_ACCEL:   accel_q   <= cfg_wdata_i[15:0];
        REG_GRAVITY: gravity_q <= cfg_wdata_i[7:0];
        default:     ;
      endcase
    end
  end

  // pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // input decode: alive test, new life, remaining life
  always_comb begin
    in_ctx_d.x_pos          = item_i.x_pos;
    in_ctx_d.y_pos          = item_i.y_pos;
    in_ctx_d.x_grad         = item_i.x_grad;
    in_ctx_d.y_grad         = item_i.y_grad;
    in_ctx_d.life_max       = item_i.life_max;
    in_ctx_d.palette_select = item_i.palette_select;
    in_ctx_d.last_in        = item_i.last_in;
    in_ctx_d.alive_in       = (item_i.life_now < item_i.life_max);
    in_ctx_d.life_next      = in_ctx_d.alive_in ? (item_i.life_now + 16'd1) : item_i.life_now;
    in_ctx_d.alive_out      = (in_ctx_d.life_next < item_i.life_max);
    in_diff_d               = item_i.life_max - item_i.life_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    in_ctx_q  <= in_ctx_d;
    in_diff_q <= in_diff_d;
  end

  // fade factor and shade index
  pmu_fade_div u_fade_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .ctx_i   (in_ctx_q),
    .diff_i  (in_diff_q),
    .valid_o (dv_vld),
    .ctx_o   (dv_ctx),
    .fade_o  (dv_fade),
    .shade_o (dv_shade)
  );

  // movement lanes
  pmu_scale u_scale_x (
    .clk_i   (clk_i),
    .grad_i  (dv_ctx.x_grad),
    .fade_i  (dv_fade),
    .accel_i (accel_q),
    .move_o  (move_x)
  );

  pmu_scale u_scale_y (
    .clk_i   (clk_i),
    .grad_i  (dv_ctx.y_grad),
    .fade_i  (dv_fade),
    .accel_i (accel_q),
    .move_o  (move_y)
  );

  // context alongside the multiplier stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc1_vld_q <= 1'b0;
      sc2_vld_q <= 1'b0;
    end else begin
      sc1_vld_q <= dv_vld;
      sc2_vld_q <= sc1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sc1_ctx_q   <= dv_ctx;
    sc1_shade_q <= dv_shade;
    sc2_ctx_q   <= sc1_ctx_q;
    sc2_shade_q <= sc1_shade_q;
  end

  // result assembly: move, gravity, shade and colour
  always_comb begin
    result_d.x_grad_next = sc2_ctx_q.x_grad;
    result_d.life_next   = sc2_ctx_q.life_next;
    result_d.alive       = sc2_ctx_q.alive_out;
    result_d.last_out    = sc2_ctx_q.last_in;
    if (sc2_ctx_q.alive_in) begin
      result_d.x_next      = sc2_ctx_q.x_pos + move_x;
      result_d.y_next      = sc2_ctx_q.y_pos + move_y;
      result_d.y_grad_next = sc2_ctx_q.y_grad + $signed({8'd0, gravity_q});
    end else begin
      result_d.x_next      = sc2_ctx_q.x_pos;
      result_d.y_next      = sc2_ctx_q.y_pos;
      result_d.y_grad_next = sc2_ctx_q.y_grad;
    end
    if (sc2_ctx_q.alive_out) begin
      result_d.shade_index = sc2_shade_q;
      result_d.colour      = pal_colour(sc2_ctx_q.palette_select, sc2_shade_q);
    end else begin
      result_d.shade_index = '0;
      result_d.colour      = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= sc2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

`ifndef NO_ASSERTIONS
  // fade factor never exceeds one for a live spark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld && dv_ctx.alive_in) |-> (dv_fade <= FADE_W'(FRAC_ONE)))
    else $error("fade factor above FRAC_ONE");

  // a dead result carries neither shade nor colour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.alive) |->
      (result_o.shade_index == '0 && result_o.colour == 8'd0))
    else $error("dead spark with shade or colour");

  // a dead input spark keeps its position and gradient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sc2_vld_q && !sc2_ctx_q.alive_in) |=>
      (result_o.x_next == $past(sc2_ctx_q.x_pos) &&
       result_o.y_grad_next == $past(sc2_ctx_q.y_grad)))
    else $error("dead spark state changed");
`endif

endmodule
